// ===== rtl/ilt_pkg.sv =====
// Shared types, codes and size constants for the indexed list table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       entry_count;
    } t_result;

endpackage

// ===== rtl/ilt_ram.sv =====
// Entry storage of the indexed list table: one write port, one read port,
// registered read data. Depends on ilt_pkg for the data width.
`timescale 1ns / 1ps

module ilt_ram #(
    parameter int CAPACITY = ilt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(CAPACITY)-1:0]        i_waddr,
    input  logic signed [ilt_pkg::DATA_W-1:0]  i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(CAPACITY)-1:0]        i_raddr,
    output logic signed [ilt_pkg::DATA_W-1:0]  o_rdata
);
    import ilt_pkg::*;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ilt_shift.sv =====
// Shift engine: walks a run of entries through the RAM, one move per cycle,
// reading one address and writing the previous read to its neighbor.
// Depends on ilt_pkg for the default capacity.
`timescale 1ns / 1ps

module ilt_shift #(
    parameter int CAPACITY = ilt_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_up,
    input  logic [$clog2(CAPACITY)-1:0]         i_from,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_moves,
    output logic                                o_re,
    output logic [$clog2(CAPACITY)-1:0]         o_raddr,
    output logic                                o_we,
    output logic [$clog2(CAPACITY)-1:0]         o_waddr,
    output logic                                o_busy
);
    import ilt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_left, n_left;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_dst,  n_dst;
    logic          r_up,   n_up;
    logic          r_pend, n_pend;

    // An upward shift (insert) walks from the tail down and writes each entry
    // one place higher; a downward shift (delete) walks up and writes lower.
    always_comb begin
        n_left = r_left;
        n_addr = r_addr;
        n_dst  = r_dst;
        n_up   = r_up;
        n_pend = 1'b0;
        if (i_start) begin
            n_left = i_moves;
            n_addr = i_from;
            n_up   = i_up;
        end else if (r_left != '0) begin
            n_left = r_left - CW'(1);
            n_pend = 1'b1;
            n_dst  = r_up ? r_addr + AW'(1) : r_addr - AW'(1);
            n_addr = r_up ? r_addr - AW'(1) : r_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pend <= 1'b0;
        end else begin
            r_left <= n_left;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_dst  <= n_dst;
        r_up   <= n_up;
    end

    assign o_re    = (r_left != '0);
    assign o_raddr = r_addr;
    assign o_we    = r_pend;
    assign o_waddr = r_dst;
    assign o_busy  = (r_left != '0) || r_pend;

endmodule

// ===== rtl/indexed_list_table_core.sv =====
// Top level of the indexed list table: command decode, entry count, sequencing
// and the result register. Depends on ilt_pkg, ilt_ram and ilt_shift.
`timescale 1ns / 1ps

// Usage
// A command is transferred at a rising edge where start is high and busy is
// low. Each command (read, insert at head, at tail or at a position, delete)
// yields exactly one result, shown on o_result for one cycle with o_strobe
// high. The receiver cannot stall, so a result is gone after that cycle.
// A refused or out-of-range command is answered straight from idle, a read
// goes through the read state, and an insert or delete runs the shift
// engine over the entries that it moves before it finishes. The moves go
// through the entry RAM with one read and one write per cycle.
// busy is high while a command is in progress and falls in the cycle its
// result is strobed, so the next command can be accepted in that cycle.
// Reset (synchronous, active low) empties the list; entry contents are not
// cleared, since only positions below the count are ever read.
module indexed_list_table_core #(
    parameter int CAPACITY = ilt_pkg::CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ilt_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_strobe,
    output ilt_pkg::t_result o_result
);
    import ilt_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ins,   n_ins;
    logic [AW-1:0]       r_at,    n_at;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic                r_strobe, n_strobe;
    t_result             r_res,    n_res;

    // Decode of the command that is being offered.
    logic [CMPW-1:0] pos_ext, cnt_ext, nxt_ext;
    logic            full, pos_lt, pos_gt;
    logic            go_read, go_ins, go_del;
    logic [CW-1:0]   at_c, cnt_m1, at_p1, cnt_next;
    t_result         early_res;

    // Shift engine and RAM hookup.
    logic            sh_start, sh_up, sh_re, sh_we, sh_busy;
    logic [AW-1:0]   sh_from, sh_raddr, sh_waddr;
    logic [CW-1:0]   sh_moves;
    logic            rd_re, fin_we, ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0] ram_wdata, ram_rdata;

    assign pos_ext = CMPW'(i_item.position);
    assign cnt_ext = CMPW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign pos_lt  = (pos_ext < cnt_ext);
    assign pos_gt  = (pos_ext > cnt_ext);

    // Range and capacity checks. A command that cannot proceed produces its
    // result right away; the others start a RAM read or a shift.
    always_comb begin
        go_read   = 1'b0;
        go_ins    = 1'b0;
        go_del    = 1'b0;
        at_c      = '0;
        early_res.read_value  = '0;
        early_res.status      = ST_RANGE;
        early_res.entry_count = cnt_ext[COUNT_W-1:0];
        unique case (i_item.command)
            CMD_READ: begin
                if (pos_lt) begin
                    go_read = 1'b1;
                end else begin
                    early_res.read_value = -32'sd1;
                end
            end
            CMD_INS_HEAD: begin
                if (full) begin
                    early_res.status = ST_FULL;
                end else begin
                    go_ins = 1'b1;
                end
            end
            CMD_INS_TAIL: begin
                if (full) begin
                    early_res.status = ST_FULL;
                end else begin
                    go_ins = 1'b1;
                    at_c   = r_count;
                end
            end
            CMD_INS_AT: begin
                // The range check takes precedence over the full check.
                if (!pos_gt) begin
                    if (full) begin
                        early_res.status = ST_FULL;
                    end else begin
                        go_ins = 1'b1;
                        at_c   = pos_ext[CW-1:0];
                    end
                end
            end
            CMD_DELETE: begin
                if (pos_lt) begin
                    go_del = 1'b1;
                    at_c   = pos_ext[CW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Insert moves entries at..count-1 up by one, starting from the tail.
    // Delete moves entries at+1..count-1 down by one, starting from at+1.
    assign cnt_m1   = r_count - CW'(1);
    assign at_p1    = at_c + CW'(1);
    assign sh_up    = go_ins;
    assign sh_from  = go_ins ? cnt_m1[AW-1:0] : at_p1[AW-1:0];
    assign sh_moves = go_ins ? (r_count - at_c) : (cnt_m1 - at_c);

    // Count after the insert or delete that is being finished.
    assign cnt_next = r_ins ? r_count + CW'(1) : r_count - CW'(1);
    assign nxt_ext  = CMPW'(cnt_next);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ins    = r_ins;
        n_at     = r_at;
        n_value  = r_value;
        n_strobe = 1'b0;
        n_res    = r_res;
        sh_start = 1'b0;
        rd_re    = 1'b0;
        fin_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (go_read) begin
                        rd_re   = 1'b1;
                        n_state = S_READ;
                    end else if (go_ins || go_del) begin
                        sh_start = 1'b1;
                        n_ins    = go_ins;
                        n_at     = at_c[AW-1:0];
                        n_value  = i_item.value;
                        n_state  = S_SHIFT;
                    end else begin
                        n_strobe = 1'b1;
                        n_res    = early_res;
                    end
                end
            end
            S_READ: begin
                n_strobe              = 1'b1;
                n_res.read_value      = ram_rdata;
                n_res.status          = ST_DONE;
                n_res.entry_count     = cnt_ext[COUNT_W-1:0];
                n_state               = S_IDLE;
            end
            S_SHIFT: begin
                // Once every move has been written back, an insert writes the new value
                // into the opened slot, and the count is updated.
                if (!sh_busy) begin
                    fin_we            = r_ins;
                    n_count           = cnt_next;
                    n_strobe          = 1'b1;
                    n_res.read_value  = '0;
                    n_res.status      = ST_DONE;
                    n_res.entry_count = nxt_ext[COUNT_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins   <= n_ins;
        r_at    <= n_at;
        r_value <= n_value;
        r_res   <= n_res;
    end

    // The shift engine and the command path never use the RAM in the same
    // cycle, so the ports are plain multiplexers.
    assign ram_we    = sh_we || fin_we;
    assign ram_waddr = sh_we ? sh_waddr : r_at;
    assign ram_wdata = sh_we ? ram_rdata : r_value;
    assign ram_re    = sh_re || rd_re;
    assign ram_raddr = sh_re ? sh_raddr : pos_ext[AW-1:0];

    ilt_shift #(
        .CAPACITY (CAPACITY)
    ) u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sh_start),
        .i_up    (sh_up),
        .i_from  (sh_from),
        .i_moves (sh_moves),
        .o_re    (sh_re),
        .o_raddr (sh_raddr),
        .o_we    (sh_we),
        .o_waddr (sh_waddr),
        .o_busy  (sh_busy)
    );

    ilt_ram #(
        .CAPACITY (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // An accepted command is either still in progress or strobes its result.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted command neither in progress nor answered");

    // The shift engine only runs while an insert or delete is in progress.
    a_shift_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sh_busy |-> (r_state == S_SHIFT))
        else $error("shift engine active outside of a shift");

    // The count only moves together with a delivered result.
    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> o_strobe)
        else $error("entry count changed without a result");

    // A full status is only reported when the list is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with free space");

endmodule
